FILE: rtl/bvba_pkg.sv
package bvba_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int IN_BITS     = 16;
  localparam int COUNT_BITS  = 8;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
  localparam int MV_BITS     = 16;
  localparam int PCT_BITS    = 7;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam int PERCENT_SCALE = 100;
  localparam int PERCENT_MAX   = 100;

  // percent divider: numerator is diff * 100, trial divisor starts at span << (PCT_BITS-1)
  localparam int NUM_BITS  = MV_BITS + PCT_BITS;
  localparam int PSTEP_BITS = $clog2(PCT_BITS);
  localparam int DSTEP_BITS = $clog2(SUM_BITS);

  localparam logic [SUM_BITS-1:0] SAMPLE_MASK = SUM_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WINDOW_LENGTH = 3'd0;
  localparam cfg_idx_t CFG_LOW_LIMIT     = 3'd1;
  localparam cfg_idx_t CFG_HIGH_LIMIT    = 3'd2;
  localparam cfg_idx_t CFG_ZERO_POINT    = 3'd3;
  localparam cfg_idx_t CFG_SPAN          = 3'd4;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_DEEP   = 2'd1,
    ST_OVER   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CLASS,
    S_PCT,
    S_LOAD
  } state_t;

endpackage

FILE: rtl/battery_voltage_block_averager.sv
// the sample that closes a window starts the serial divide (S_DIV), then S_CLASS, then the
// percent division (S_PCT) unless it needs none (not normal, at or below zero point,
// saturated), then S_LOAD, which sets out_valid; one sample per cycle inside a window;
// after the closing sample the input stalls until the result is loaded, longer while the
// previous result still waits at the output
// reset: synchronous active-low rst_n clears sum, count, state, out_valid and loads
// register defaults (10, 3000, 4200, 3000, 1200)
module battery_voltage_block_averager (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bvba_pkg::IN_BITS-1:0]      in_sample_mv,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bvba_pkg::MV_BITS-1:0]      out_average_mv,
  output logic [1:0]                        out_level_status,
  output logic [bvba_pkg::PCT_BITS-1:0]     out_percent,
  input  logic                              cfg_we,
  input  bvba_pkg::cfg_idx_t                cfg_index,
  input  logic [bvba_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import bvba_pkg::*;

  logic [COUNT_BITS-1:0] window_length_r;
  logic [MV_BITS-1:0]    low_limit_r;
  logic [MV_BITS-1:0]    high_limit_r;
  logic [MV_BITS-1:0]    zero_point_r;
  logic [MV_BITS-1:0]    span_r;

  state_t                state_r, state_nxt;
  logic [SUM_BITS-1:0]   sum_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [SUM_BITS-1:0]   avg_r;
  status_t               status_r;
  logic [PCT_BITS-1:0]   pct_r;
  logic [NUM_BITS-1:0]   prem_r;
  logic [NUM_BITS-1:0]   pdvs_r;
  logic [PSTEP_BITS-1:0] pstep_r;

  logic                  out_valid_r;
  logic [MV_BITS-1:0]    out_avg_r;
  status_t               out_status_r;
  logic [PCT_BITS-1:0]   out_pct_r;

  logic                  in_xfer, out_xfer;
  logic [SUM_BITS-1:0]   sum_add;
  logic [COUNT_BITS-1:0] cnt_add;
  logic                  acc_fire;
  logic                  div_done;
  logic [SUM_BITS-1:0]   div_quo;

  status_t               class_status;
  logic [MV_BITS-1:0]    diff;
  logic [NUM_BITS-1:0]   num;
  logic [NUM_BITS-1:0]   sat_bound;
  logic                  above_zero;
  logic                  pct_ge;
  logic                  load_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign load_ok   = !out_valid_r || !out_stall;

  always_comb begin
    sum_add  = sum_r + (SUM_BITS'(in_sample_mv) & SAMPLE_MASK);
    cnt_add  = cnt_r + 1'b1;
    acc_fire = in_xfer && (cnt_add != '0) && (cnt_add >= window_length_r);
  end

  bvba_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (acc_fire),
    .dividend (sum_add),
    .divisor  (cnt_add),
    .done     (div_done),
    .quotient (div_quo)
  );

  // classification; in the normal case avg never exceeds the high limit, so diff fits
  always_comb begin
    if (avg_r < SUM_BITS'(low_limit_r)) begin
      class_status = ST_DEEP;
    end else if (avg_r > SUM_BITS'(high_limit_r)) begin
      class_status = ST_OVER;
    end else begin
      class_status = ST_NORMAL;
    end
    above_zero = avg_r > SUM_BITS'(zero_point_r);
    diff       = MV_BITS'(avg_r - SUM_BITS'(zero_point_r));
    num        = NUM_BITS'({diff, 6'd0}) + NUM_BITS'({diff, 5'd0}) + NUM_BITS'({diff, 2'd0});
    // q > 100 exactly when num >= 101 * span
    sat_bound  = NUM_BITS'({span_r, 6'd0}) + NUM_BITS'({span_r, 5'd0})
               + NUM_BITS'({span_r, 2'd0}) + NUM_BITS'(span_r);
    pct_ge     = prem_r >= pdvs_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc_fire) state_nxt = S_DIV;
      S_DIV:   if (div_done) state_nxt = S_CLASS;
      S_CLASS: begin
        if (class_status == ST_NORMAL && above_zero && num < sat_bound) begin
          state_nxt = S_PCT;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_PCT:   if (pstep_r == '0) state_nxt = S_LOAD;
      S_LOAD:  if (load_ok) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= 8'd10;
      low_limit_r     <= 16'd3000;
      high_limit_r    <= 16'd4200;
      zero_point_r    <= 16'd3000;
      span_r          <= 16'd1200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata[COUNT_BITS-1:0];
        CFG_LOW_LIMIT:     low_limit_r     <= cfg_wdata[MV_BITS-1:0];
        CFG_HIGH_LIMIT:    high_limit_r    <= cfg_wdata[MV_BITS-1:0];
        CFG_ZERO_POINT:    zero_point_r    <= cfg_wdata[MV_BITS-1:0];
        CFG_SPAN:          span_r          <= cfg_wdata[MV_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (acc_fire) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (in_xfer) begin
      sum_r <= sum_add;
      cnt_r <= cnt_add;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV && div_done) begin
      avg_r <= div_quo;
    end
    if (state_r == S_CLASS) begin
      status_r <= class_status;
      prem_r   <= num;
      pdvs_r   <= NUM_BITS'({span_r, 6'd0});
      pstep_r  <= PSTEP_BITS'(PCT_BITS - 1);
      if (class_status != ST_NORMAL || !above_zero) begin
        pct_r <= '0;
      end else if (num >= sat_bound) begin
        pct_r <= PCT_BITS'(PERCENT_MAX);
      end else begin
        pct_r <= '0;
      end
    end else if (state_r == S_PCT) begin
      // one percent bit per cycle, divisor walks right
      prem_r  <= pct_ge ? (prem_r - pdvs_r) : prem_r;
      pdvs_r  <= pdvs_r >> 1;
      pct_r   <= {pct_r[PCT_BITS-2:0], pct_ge};
      pstep_r <= pstep_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_LOAD && load_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && load_ok) begin
      out_avg_r    <= avg_r[MV_BITS-1:0];
      out_status_r <= status_r;
      out_pct_r    <= pct_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average_mv   = out_avg_r;
  assign out_level_status = out_status_r;
  assign out_percent      = out_pct_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide phase");

  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    acc_fire |=> (sum_r == '0 && cnt_r == '0 && state_r == S_DIV))
    else $error("window not cleared after closing sample");

  a_pct_zero_abnormal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_NORMAL) |-> out_pct_r == '0)
    else $error("nonzero percent with abnormal status");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= PCT_BITS'(PERCENT_MAX))
    else $error("percent above saturation");

endmodule

FILE: rtl/bvba_serdiv.sv
module bvba_serdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bvba_pkg::SUM_BITS-1:0]   dividend,
  input  logic [bvba_pkg::COUNT_BITS-1:0] divisor,
  output logic                          done,
  output logic [bvba_pkg::SUM_BITS-1:0]   quotient
);
  import bvba_pkg::*;

  logic                    busy_r;
  logic                    done_r;
  logic [DSTEP_BITS-1:0]   step_r;
  logic [COUNT_BITS:0]     rem_r;
  logic [SUM_BITS-1:0]     quo_r;
  logic [COUNT_BITS-1:0]   dvs_r;

  logic [COUNT_BITS:0]     shifted;
  logic                    ge;
  logic [COUNT_BITS:0]     rem_nxt;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r[COUNT_BITS-1:0], quo_r[SUM_BITS-1]};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? (shifted - {1'b0, dvs_r}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
      step_r <= DSTEP_BITS'(SUM_BITS - 1);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[SUM_BITS-2:0], ge};
      step_r <= step_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
